/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHK_IMPLY(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define CHK_NEXT(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gjpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gjpd_pkg;

    localparam int QIDX_W = 2;
    localparam int LIMIT_CAP = 16;

    localparam logic [1:0] ACT_SUBMIT   = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_CANCEL   = 2'd2;
    localparam logic [1:0] ACT_SCHEDULE = 2'd3;

    localparam logic [1:0] RES_SUBMIT   = 2'd0;
    localparam logic [1:0] RES_DISPATCH = 2'd1;
    localparam logic [1:0] RES_FINISHED = 2'd2;
    localparam logic [1:0] RES_CANCEL   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    localparam logic CFG_QUEUES = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] job_tag;
        logic [1:0]  job_kind;
        logic [1:0]  job_level;
        logic [3:0]  queue_select;
        logic [47:0] command_address;
        logic [19:0] command_bytes;
        logic [47:0] fence_address;
        logic [31:0] fence_word;
        logic        engine_busy;
        logic        engine_error;
    } job_req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  status_code;
        logic [1:0]  queue_index;
        logic [15:0] out_tag;
        logic [47:0] out_command_address;
        logic [19:0] out_command_bytes;
        logic [47:0] out_fence_address;
        logic [31:0] out_fence_word;
        logic        fence_requested;
        logic        last_result;
    } job_res_t;

    typedef struct packed {
        logic [47:0] command_address;
        logic [19:0] command_bytes;
        logic [47:0] fence_address;
        logic [31:0] fence_word;
    } job_data_t;

endpackage
`default_nettype wire

/* rtl/gpu_job_priority_dispatcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// Job dispatcher with strict priority per hardware queue.
// Requests arrive on start/req and are taken when busy is low; results leave
// on res, each marked by res_valid for one cycle, the last one of a request
// flagged by last_result. The receiver cannot stall, so results are never held.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and the user must make writes while the block is
// idle; the block does not enforce this. A submit scans the slot table for a
// free slot, a cancel scans it for the oldest job carrying the tag, and a
// schedule pass scans it once per eligible queue. Each scan visits one slot
// per cycle; cancel and schedule scans rank slots through the shared compare
// unit, and the slot memory has a registered read port.
// Each dispatch of a pass is held until the next one is found or the pass ends,
// so that only the final one carries last_result.
// Slot data lives in a memory with no reset; only the per-slot valid and phase
// bits are cleared by reset, together with the running and started records of
// each queue, the age counter and the registers (one queue, limit sixteen).
// A result is shown in the cycle after its decision and busy drops after the last.
module gpu_job_priority_dispatcher #(
    parameter int MAX_QUEUES      = 4,
    parameter int JOB_SLOTS       = 64,
    parameter int PRIORITY_LEVELS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire gjpd_pkg::job_req_t req,
    output logic                    res_valid,
    output gjpd_pkg::job_res_t      res,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [4:0]         cfg_data
);
    import gjpd_pkg::*;

    localparam int SW = $clog2(JOB_SLOTS);
    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam logic [SW:0] LAST_SLOT = (SW+1)'(JOB_SLOTS - 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_READ, S_EMIT, S_NEXTQ}
        state_t;

    // Slot memory: meta and payload, written at submit, read one slot a cycle.
    logic [SW-1:0] mem_addr;
    logic [LW+QW+31:0] meta_mem [JOB_SLOTS];
    job_data_t         data_mem [JOB_SLOTS];
    logic [LW+QW+31:0] meta_rd;
    job_data_t         data_rd;
    logic              wr_en;
    logic [SW-1:0]     wr_addr;
    logic [LW+QW+31:0] wr_meta;

    logic [JOB_SLOTS-1:0] valid_reg, phase_reg;
    logic [SW:0]          run_reg [MAX_QUEUES];
    logic [4:0]           started_reg [MAX_QUEUES];
    logic [15:0]          order_reg;
    logic [2:0]           nq_reg;
    logic [4:0]           lim_reg;

    state_t        state_reg;
    job_req_t      req_reg;
    logic [SW:0]   ptr_reg;
    logic [SW-1:0] rd_slot_reg;
    logic          rd_v_reg;
    logic          have_reg;
    logic [SW-1:0] best_reg;
    logic [LW-1:0] best_lvl_reg;
    logic [15:0]   best_age_reg;
    logic [QW-1:0] best_q_reg;
    logic [QW:0]   q_reg;
    logic          any_reg;
    logic          fetch_reg;
    job_res_t      res_reg;
    logic          res_v_reg;

    logic [LW-1:0] c_lvl;
    logic [QW-1:0] c_q;
    logic [15:0]   c_order, c_tag, c_age;
    logic          better, match;
    logic [2:0]    nq_eff;
    logic [4:0]    lim_eff;
    logic [QW-1:0] sub_q;
    logic [LW-1:0] sub_lvl;
    logic [QW-1:0] q_cur;

    assign {c_lvl, c_q, c_order, c_tag} = meta_rd;
    assign c_age = order_reg - c_order;
    assign q_cur = q_reg[QW-1:0];

    always_comb
    begin
        nq_eff = nq_reg;
        if (nq_eff < 3'd1) nq_eff = 3'd1;
        if (nq_eff > 3'd4) nq_eff = 3'd4;
        if (32'(nq_eff) > MAX_QUEUES) nq_eff = 3'(MAX_QUEUES);
        lim_eff = lim_reg;
        if (lim_eff < 5'd1) lim_eff = 5'd1;
        if (lim_eff > 5'(LIMIT_CAP)) lim_eff = 5'(LIMIT_CAP);
    end

    always_comb
    begin
        logic [3:0] qs;
        qs = req_reg.queue_select;
        if ({1'b0, qs} >= {2'b0, nq_eff}) begin
            if (req_reg.job_kind == 2'd1) qs = (nq_eff > 3'd1) ? 4'd1 : 4'd0;
            else if (req_reg.job_kind == 2'd2) qs = (nq_eff > 3'd2) ? 4'd2 : 4'd0;
            else qs = 4'd0;
        end
        sub_q = QW'(qs);
        if (32'(req_reg.job_level) >= PRIORITY_LEVELS) sub_lvl = LW'(PRIORITY_LEVELS - 1);
        else sub_lvl = LW'(req_reg.job_level);
    end

    always_comb
    begin
        case (req_reg.action)
            ACT_CANCEL:   match = valid_reg[rd_slot_reg] && c_tag == req_reg.job_tag;
            ACT_SCHEDULE: match = valid_reg[rd_slot_reg] && !phase_reg[rd_slot_reg]
                                  && c_q == q_cur;
            default:      match = 1'b0;
        endcase
    end

    gjpd_scan_cmp #(.LEVEL_W(LW)) u_cmp (
        .use_level (req_reg.action == ACT_SCHEDULE),
        .have_best (have_reg),
        .cand_level(c_lvl),
        .best_level(best_lvl_reg),
        .cand_age  (c_age),
        .best_age  (best_age_reg),
        .better    (better)
    );

    assign mem_addr = fetch_reg ? best_reg : ptr_reg[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            meta_mem[wr_addr] <= wr_meta;
            data_mem[wr_addr] <= {req_reg.command_address, req_reg.command_bytes,
                                  req_reg.fence_address, req_reg.fence_word};
        end
        meta_rd <= meta_mem[mem_addr];
        data_rd <= data_mem[mem_addr];
    end

    assign wr_en = state_reg == S_DECIDE && req_reg.action == ACT_SUBMIT && have_reg;
    assign wr_addr = best_reg;
    assign wr_meta = {sub_lvl, sub_q, order_reg, req_reg.job_tag};

    function automatic job_res_t mk(logic [1:0] k, logic [1:0] s, logic [QW-1:0] q,
                                    logic [15:0] t, logic l);
        job_res_t r;
        r = '0;
        r.result_kind = k;
        r.status_code = s;
        r.queue_index = 2'(q);
        r.out_tag = t;
        r.last_result = l;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            phase_reg <= '0;
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                run_reg[i] <= (SW+1)'(JOB_SLOTS);
                started_reg[i] <= '0;
            end
            order_reg <= '0;
            nq_reg <= 3'd1;
            lim_reg <= 5'(LIMIT_CAP);
            res_v_reg <= 1'b0;
            fetch_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            have_reg <= 1'b0;
            any_reg <= 1'b0;
            ptr_reg <= '0;
            q_reg <= '0;
        end
        else
        begin
            logic res_v_next;
            logic fetch_next;
            res_v_next = 1'b0;
            fetch_next = 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_QUEUES) nq_reg <= cfg_data[2:0];
                else lim_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        req_reg <= req;
                        ptr_reg <= '0;
                        rd_v_reg <= 1'b0;
                        have_reg <= 1'b0;
                        any_reg <= 1'b0;
                        q_reg <= '0;
                        if (req.action == ACT_COMPLETE)
                            state_reg <= S_READ;
                        else if (req.action == ACT_SCHEDULE
                                 && !(run_reg[0] > LAST_SLOT && started_reg[0] < lim_eff))
                            // The first queue of a schedule pass may be ineligible.
                            state_reg <= S_NEXTQ;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Slot ptr is being addressed; slot rd_slot_reg's data is on meta_rd.
                    rd_slot_reg <= ptr_reg[SW-1:0];
                    rd_v_reg <= ptr_reg <= LAST_SLOT;
                    if (ptr_reg <= LAST_SLOT) ptr_reg <= ptr_reg + 1'b1;
                    if (req_reg.action == ACT_SUBMIT)
                    begin
                        if (rd_v_reg && !have_reg && !valid_reg[rd_slot_reg])
                        begin
                            have_reg <= 1'b1;
                            best_reg <= rd_slot_reg;
                        end
                    end
                    else if (rd_v_reg && match && better)
                    begin
                        have_reg <= 1'b1;
                        best_reg <= rd_slot_reg;
                        best_lvl_reg <= c_lvl;
                        best_age_reg <= c_age;
                        best_q_reg <= c_q;
                    end
                    if (rd_v_reg && rd_slot_reg == LAST_SLOT[SW-1:0])
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    case (req_reg.action)
                        ACT_SUBMIT:
                        begin
                            res_v_next = 1'b1;
                            state_reg <= S_IDLE;
                            if (req_reg.command_address == '0 || req_reg.command_bytes == '0)
                                res_reg <= mk(RES_SUBMIT, ST_INVALID, '0, req_reg.job_tag, 1'b1);
                            else if (!have_reg)
                                res_reg <= mk(RES_SUBMIT, ST_FULL, sub_q, req_reg.job_tag, 1'b1);
                            else
                            begin
                                res_reg <= mk(RES_SUBMIT, ST_OK, sub_q, req_reg.job_tag, 1'b1);
                                valid_reg[best_reg] <= 1'b1;
                                phase_reg[best_reg] <= 1'b0;
                                order_reg <= order_reg + 16'd1;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            res_v_next = 1'b1;
                            state_reg <= S_IDLE;
                            if (!have_reg)
                                res_reg <= mk(RES_CANCEL, ST_ABSENT, '0, req_reg.job_tag, 1'b1);
                            else if (phase_reg[best_reg])
                                res_reg <= mk(RES_CANCEL, ST_RUNNING, best_q_reg,
                                              req_reg.job_tag, 1'b1);
                            else
                            begin
                                res_reg <= mk(RES_CANCEL, ST_OK, best_q_reg,
                                              req_reg.job_tag, 1'b1);
                                valid_reg[best_reg] <= 1'b0;
                            end
                        end
                        default:
                        begin
                            // Schedule: fetch the winner's payload. A dispatch held
                            // from an earlier queue is not the last, so it goes out now.
                            if (have_reg)
                            begin
                                if (any_reg) res_v_next = 1'b1;
                                fetch_next = 1'b1;
                                state_reg <= S_EMIT;
                            end
                            else
                                state_reg <= S_NEXTQ;
                        end
                    endcase
                end
                S_READ:
                begin
                    // Completion: fetch the running job's tag.
                    if (32'(req_reg.queue_select) >= MAX_QUEUES || req_reg.engine_busy
                        || run_reg[QW'(req_reg.queue_select)] > LAST_SLOT)
                        state_reg <= S_IDLE;
                    else
                    begin
                        best_reg <= run_reg[QW'(req_reg.queue_select)][SW-1:0];
                        fetch_next = 1'b1;
                        have_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    job_res_t disp;
                    disp = mk(RES_DISPATCH, ST_OK, q_cur, c_tag, 1'b0);
                    disp.out_command_address = data_rd.command_address;
                    disp.out_command_bytes = data_rd.command_bytes;
                    disp.out_fence_address = data_rd.fence_address;
                    disp.out_fence_word = data_rd.fence_word;
                    disp.fence_requested = data_rd.fence_address != '0;
                    if (!fetch_reg)
                    begin
                        if (req_reg.action == ACT_COMPLETE)
                        begin
                            res_v_next = 1'b1;
                            res_reg <= mk(RES_FINISHED, {1'b0, req_reg.engine_error},
                                          QW'(req_reg.queue_select), c_tag, 1'b1);
                            valid_reg[best_reg] <= 1'b0;
                            run_reg[QW'(req_reg.queue_select)] <= (SW+1)'(JOB_SLOTS);
                            if (started_reg[QW'(req_reg.queue_select)] != '0)
                                started_reg[QW'(req_reg.queue_select)] <=
                                    started_reg[QW'(req_reg.queue_select)] - 5'd1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            res_reg <= disp;
                            phase_reg[best_reg] <= 1'b1;
                            run_reg[q_cur] <= {1'b0, best_reg};
                            started_reg[q_cur] <= started_reg[q_cur] + 5'd1;
                            any_reg <= 1'b1;
                            state_reg <= S_NEXTQ;
                        end
                    end
                end
                S_NEXTQ:
                begin
                    // A held dispatch is released at the end of the pass as the last.
                    logic [QW:0] nxt;
                    logic        found;
                    nxt = q_reg + 1'b1;
                    found = 1'b0;
                    if ({1'b0, nxt} < {1'b0, (QW+1)'(nq_eff)})
                    begin
                        if (run_reg[nxt[QW-1:0]] > LAST_SLOT
                            && started_reg[nxt[QW-1:0]] < lim_eff)
                            found = 1'b1;
                    end
                    q_reg <= nxt;
                    have_reg <= 1'b0;
                    ptr_reg <= '0;
                    rd_v_reg <= 1'b0;
                    if ({1'b0, nxt} >= {1'b0, (QW+1)'(nq_eff)})
                    begin
                        if (any_reg)
                        begin
                            res_v_next = 1'b1;
                            res_reg.last_result <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (found)
                        state_reg <= S_SCAN;
                    else
                        state_reg <= S_NEXTQ;
                end
                default: state_reg <= S_IDLE;
            endcase
            res_v_reg <= res_v_next;
            fetch_reg <= fetch_next;
        end
    end

    assign busy = state_reg != S_IDLE || res_v_reg;
    assign res_valid = res_v_reg;
    assign res = res_reg;
    assign cfg_ready = 1'b1;
endmodule
`default_nettype wire

/* rtl/gjpd_scan_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared compare unit: decides whether the slot now being visited beats the
// best candidate found so far in a table scan.
module gjpd_scan_cmp #(
    parameter int LEVEL_W = 2
) (
    input  wire logic               use_level,
    input  wire logic               have_best,
    input  wire logic [LEVEL_W-1:0] cand_level,
    input  wire logic [LEVEL_W-1:0] best_level,
    input  wire logic [15:0]        cand_age,
    input  wire logic [15:0]        best_age,
    output logic                    better
);
    always_comb
    begin
        if (!have_best)
            better = 1'b1;
        else if (use_level && cand_level != best_level)
            better = cand_level > best_level;
        else
            better = cand_age > best_age;
    end
endmodule
`default_nettype wire

/* rtl/gjpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the dispatcher.
module gjpd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               res_valid,
    input wire gjpd_pkg::job_res_t res
);
    import gjpd_pkg::*;

    `CHK_NEXT(a_start_busy, rst_n, start && !busy, busy, "busy did not rise after a request")
    `CHK_IMPLY(a_res_busy, rst_n, res_valid, busy, "result shown while idle")
    `CHK_IMPLY(a_data_zero, rst_n, res_valid && res.result_kind != RES_DISPATCH,
        res.out_command_address == '0, "job data on a non-dispatch result")
    `CHK_IMPLY(a_fence, rst_n, res_valid,
        res.fence_requested == (res.out_fence_address != '0), "fence flag mismatch")
endmodule

bind gpu_job_priority_dispatcher gjpd_checker u_gjpd_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .res_valid(res_valid), .res(res)
);
`default_nettype wire

/* tb/sv/gpu_job_priority_dispatcher_test.sv */
`timescale 1ns / 1ps
module gpu_job_priority_dispatcher_test;
    import gjpd_pkg::*;

    localparam int NQ = 4;
    localparam int NSLOT = 64;
    localparam int NONE = NSLOT;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    job_req_t req = '0;
    logic res_valid;
    job_res_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    gpu_job_priority_dispatcher dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .res_valid(res_valid), .res(res), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the job table, kept in step with every accepted request.
    logic        jv [NSLOT];
    logic        jrun [NSLOT];
    logic [1:0]  jq [NSLOT];
    logic [1:0]  jlvl [NSLOT];
    logic [15:0] jord [NSLOT];
    logic [15:0] jtag [NSLOT];
    job_data_t   jdat [NSLOT];
    int          run_slot [NQ];
    int          started [NQ];
    logic [15:0] age_ctr;
    logic [2:0]  sh_queues;
    logic [4:0]  sh_limit;

    job_req_t pending_reqs[$];
    job_res_t awaited[$];
    int mismatches = 0;
    int cycles = 0;
    bit gap_armed = 1'b0;
    int gap = 0;

    function automatic logic [15:0] age(int s);
        return age_ctr - jord[s];
    endfunction

    function automatic job_res_t mk(logic [1:0] k, logic [1:0] st, logic [1:0] q,
                                    logic [15:0] tag);
        job_res_t r;
        r = '0;
        r.result_kind = k;
        r.status_code = st;
        r.queue_index = q;
        r.out_tag = tag;
        r.last_result = 1'b1;
        return r;
    endfunction

    // Works out the results of one request and updates the shadow table.
    task automatic predict_request(input job_req_t r);
        int nq, lim, q, s, best, n;
        job_res_t o;
        nq = (sh_queues < 1) ? 1 : (sh_queues > 4) ? 4 : int'(sh_queues);
        lim = (sh_limit < 1) ? 1 : (sh_limit > 16) ? 16 : int'(sh_limit);
        case (r.action)
            ACT_SUBMIT:
            begin
                if (r.command_address == 0 || r.command_bytes == 0)
                begin
                    awaited.push_back(mk(RES_SUBMIT, ST_INVALID, 2'd0, r.job_tag));
                end
                else
                begin
                    q = int'(r.queue_select);
                    if (q >= nq)
                    begin
                        if (r.job_kind == 2'd1) q = (nq > 1) ? 1 : 0;
                        else if (r.job_kind == 2'd2) q = (nq > 2) ? 2 : 0;
                        else q = 0;
                    end
                    best = -1;
                    for (s = 0; s < NSLOT; s++)
                        if (!jv[s] && best < 0) best = s;
                    if (best < 0)
                    begin
                        awaited.push_back(mk(RES_SUBMIT, ST_FULL, q[1:0], r.job_tag));
                    end
                    else
                    begin
                        jv[best] = 1'b1;
                        jrun[best] = 1'b0;
                        jq[best] = q[1:0];
                        jlvl[best] = r.job_level;
                        jord[best] = age_ctr;
                        jtag[best] = r.job_tag;
                        jdat[best] = {r.command_address, r.command_bytes,
                                      r.fence_address, r.fence_word};
                        age_ctr = age_ctr + 16'd1;
                        awaited.push_back(mk(RES_SUBMIT, ST_OK, q[1:0], r.job_tag));
                    end
                end
            end
            ACT_COMPLETE:
            begin
                q = int'(r.queue_select);
                if (q < NQ && !r.engine_busy && run_slot[q] != NONE)
                begin
                    s = run_slot[q];
                    if (started[q] > 0) started[q]--;
                    run_slot[q] = NONE;
                    jv[s] = 1'b0;
                    awaited.push_back(mk(RES_FINISHED, {1'b0, r.engine_error}, q[1:0],
                                         jtag[s]));
                end
            end
            ACT_CANCEL:
            begin
                best = -1;
                for (s = 0; s < NSLOT; s++)
                    if (jv[s] && jtag[s] == r.job_tag)
                        if (best < 0 || age(s) > age(best)) best = s;
                if (best < 0)
                    awaited.push_back(mk(RES_CANCEL, ST_ABSENT, 2'd0, r.job_tag));
                else if (jrun[best])
                    awaited.push_back(mk(RES_CANCEL, ST_RUNNING, jq[best], r.job_tag));
                else
                begin
                    jv[best] = 1'b0;
                    awaited.push_back(mk(RES_CANCEL, ST_OK, jq[best], r.job_tag));
                end
            end
            default:
            begin
                n = 0;
                for (q = 0; q < nq; q++)
                begin
                    if (run_slot[q] == NONE && started[q] < lim)
                    begin
                        best = -1;
                        for (s = 0; s < NSLOT; s++)
                            if (jv[s] && !jrun[s] && jq[s] == q)
                                if (best < 0 || jlvl[s] > jlvl[best] ||
                                    (jlvl[s] == jlvl[best] && age(s) > age(best)))
                                    best = s;
                        if (best >= 0)
                        begin
                            jrun[best] = 1'b1;
                            run_slot[q] = best;
                            started[q]++;
                            o = mk(RES_DISPATCH, ST_OK, q[1:0], jtag[best]);
                            o.last_result = 1'b0;
                            {o.out_command_address, o.out_command_bytes,
                             o.out_fence_address, o.out_fence_word} = jdat[best];
                            o.fence_requested = (jdat[best].fence_address != 0);
                            awaited.push_back(o);
                            n++;
                        end
                    end
                end
                // Only the final dispatch of a pass carries the last flag.
                if (n > 0) awaited[$].last_result = 1'b1;
            end
        endcase
    endtask

    // Driver: takes requests from the pending queue, waiting a random number
    // of cycles before each one. The prediction is made at acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_request(req);
                void'(pending_reqs.pop_front());
                gap_armed = 1'b0;
            end
            if (start && busy)
            begin
                // Hold the request until it is taken.
            end
            else if (pending_reqs.size() > 0)
            begin
                if (!gap_armed)
                begin
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
                    gap_armed = 1'b1;
                end
                if (gap > 0)
                begin
                    gap--;
                    start <= 1'b0;
                end
                else
                begin
                    req <= pending_reqs[0];
                    start <= 1'b1;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && res_valid)
        begin
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res);
            end
            else
            begin
                if (res !== awaited[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h",
                                 awaited[0], res);
                end
                void'(awaited.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gpu_job_priority_dispatcher_test: errors");
            $finish;
        end
    end

    function automatic job_req_t rand_req(logic [1:0] act);
        job_req_t r;
        r.action = act;
        r.job_tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        r.job_kind = 2'($urandom);
        r.job_level = 2'($urandom);
        r.queue_select = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        r.command_address = 48'({$urandom, $urandom});
        r.command_bytes = 20'($urandom);
        r.fence_address = $urandom_range(0, 1) ? 48'd0 : 48'({$urandom, $urandom});
        r.fence_word = $urandom;
        r.engine_busy = ($urandom_range(0, 4) == 0);
        r.engine_error = 1'($urandom);
        if ($urandom_range(0, 15) == 0) r.command_address = '0;
        if ($urandom_range(0, 15) == 0) r.command_bytes = '0;
        return r;
    endfunction

    task automatic push(job_req_t r);
        pending_reqs.push_back(r);
    endtask

    // Waits for the block to drain, then writes one register.
    task automatic write_reg(logic idx, logic [4:0] val);
        while (pending_reqs.size() > 0 || awaited.size() > 0 || start || busy)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_QUEUES) sh_queues = val[2:0];
        else sh_limit = val;
    endtask

    initial
    begin
        job_req_t r;
        int i, ph;
        for (i = 0; i < NSLOT; i++)
        begin
            jv[i] = 1'b0;
            jrun[i] = 1'b0;
        end
        for (i = 0; i < NQ; i++)
        begin
            run_slot[i] = NONE;
            started[i] = 0;
        end
        age_ctr = 16'd0;
        sh_queues = 3'd1;
        sh_limit = 5'd16;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one queue, extremes of the fields, every action.
        r = rand_req(ACT_SUBMIT);
        r.command_address = '1; r.command_bytes = '1; r.fence_address = '1;
        r.fence_word = '1; r.job_tag = '1; r.job_level = 2'd3;
        r.queue_select = 4'hF; r.job_kind = 2'd1;
        push(r);
        r.job_tag = 16'd0; r.job_level = 2'd0; r.fence_address = '0;
        r.queue_select = 4'd0; push(r);
        r.command_address = '0; push(r);
        r.command_address = 48'd1; r.command_bytes = '0; push(r);
        r = rand_req(ACT_CANCEL); r.job_tag = 16'd0; push(r);
        r.job_tag = 16'h1234; push(r);
        r = rand_req(ACT_SCHEDULE); push(r);
        push(r);
        r = rand_req(ACT_CANCEL); r.job_tag = 16'hFFFF; push(r);
        r = rand_req(ACT_COMPLETE); r.queue_select = 4'd0; r.engine_busy = 1'b1; push(r);
        r.queue_select = 4'd9; r.engine_busy = 1'b0; push(r);
        r.queue_select = 4'd2; push(r);
        r.queue_select = 4'd0; r.engine_error = 1'b1; push(r);
        push(r);
        r = rand_req(ACT_SCHEDULE); push(r);

        // Phases under different settings, extremes and out-of-range values.
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_QUEUES, 5'd4); write_reg(CFG_LIMIT, 5'd1); end
                1: begin write_reg(CFG_QUEUES, 5'd0); write_reg(CFG_LIMIT, 5'd0); end
                2: begin write_reg(CFG_QUEUES, 5'd7); write_reg(CFG_LIMIT, 5'd31); end
                3: begin write_reg(CFG_QUEUES, 5'd2); write_reg(CFG_LIMIT, 5'd3); end
                4: begin write_reg(CFG_QUEUES, 5'd3); write_reg(CFG_LIMIT, 5'd16); end
                default: begin write_reg(CFG_QUEUES, 5'd4); write_reg(CFG_LIMIT, 5'd2); end
            endcase
            // Mostly submit, schedule and complete cycles, with cancels mixed in.
            for (i = 0; i < (ph == 5 ? 15 : 3); i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push(rand_req(ACT_SUBMIT));
                    4, 5: push(rand_req(ACT_SCHEDULE));
                    6, 7: push(rand_req(ACT_COMPLETE));
                    default: push(rand_req(ACT_CANCEL));
                endcase
            end
        end
        // Fill the table once to reach the full case.
        for (i = 0; i < 66; i++)
        begin
            r = rand_req(ACT_SUBMIT);
            r.command_address = 48'd5; r.command_bytes = 20'd5;
            push(r);
        end
        push(rand_req(ACT_SCHEDULE));

        while (pending_reqs.size() > 0 || awaited.size() > 0 || start)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("gpu_job_priority_dispatcher_test: clean");
        else
            $display("gpu_job_priority_dispatcher_test: errors");
        $finish;
    end
endmodule
